>>> hdl/keyframe_flushing_packet_queue_unit_defines.svh
// Assertion macros for the keyframe flushing packet queue.
// Included by the top level; expects clk and rst in scope.
`ifndef KEYFRAME_FLUSHING_PACKET_QUEUE_UNIT_DEFINES_SVH
`define KEYFRAME_FLUSHING_PACKET_QUEUE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// condition holds in the same cycle
`define KFQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kfq same-cycle check failed");
// condition holds in the following cycle
`define KFQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kfq next-cycle check failed");
// condition holds at every edge
`define KFQ_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("kfq invariant failed");
`else
`define KFQ_ASSERT_SAME(label, ante, cons)
`define KFQ_ASSERT_NEXT(label, ante, cons)
`define KFQ_ASSERT_ALWAYS(label, cond)
`endif
`endif

>>> hdl/kfq_pkg.sv
// Types and constants shared by the keyframe flushing packet queue.
// No dependencies.
package kfq_pkg;

  localparam int HANDLE_W  = 16;
  localparam int KEY_W     = 8;
  localparam int FRAME_W   = 16;
  localparam int SEG_W     = 8;
  localparam int RUN_W     = 9;
  localparam int DROP_W    = 9;

  localparam logic       OP_PUSH  = 1'b0;
  localparam logic       OP_PULL  = 1'b1;
  localparam logic [KEY_W-1:0] KEY_MARK  = 8'd1;
  localparam logic [SEG_W-1:0] SEG_START = 8'd0;
  localparam logic [RUN_W-1:0] RUN_MAX   = 9'd511;
  // last keyframe number before any was recorded: minus one
  localparam logic signed [FRAME_W:0] LAST_KEY_RESET = -17'sd1;

  typedef struct packed {
    logic                opcode;
    logic [HANDLE_W-1:0] packet_handle;
    logic [KEY_W-1:0]    key_flag_byte;
    logic [FRAME_W-1:0]  frame_number;
    logic [SEG_W-1:0]    segment_byte;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] out_handle;
    logic                out_valid;
    logic [DROP_W-1:0]   dropped_count;
    logic                push_refused;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic push;
    logic pull_read;
    logic pull_empty;
    logic pull_done;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic nonempty;
  } status_t;

endpackage

>>> hdl/kfq_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module kfq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/kfq_ctrl.sv
// Controller state machine of the packet queue.
// Depends on kfq_pkg.
module kfq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic             opcode,
  input  kfq_pkg::status_t status,
  input  logic             out_space,
  output kfq_pkg::cmd_t    cmd,
  output kfq_pkg::state_t  state
);
  import kfq_pkg::*;

  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = !out_space;
        if (req_valid && out_space) begin
          if (opcode == OP_PULL) begin
            if (status.nonempty) begin
              cmd.pull_read = 1'b1;
              state_next    = ST_READ;
            end else begin
              cmd.pull_empty = 1'b1;
            end
          end else begin
            cmd.push = 1'b1;
          end
        end
      end
      ST_READ: begin
        // store data arrives, hand result to output buffer
        cmd.pull_done = 1'b1;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/kfq_dpath.sv
// Datapath of the packet queue: pointers, run counter, flush logic, store.
// Depends on kfq_pkg and kfq_ram.
module kfq_dpath #(
  parameter int QUEUE_DEPTH = 256,
  parameter int HANDLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  kfq_pkg::req_t    req,
  input  kfq_pkg::cmd_t    cmd,
  output kfq_pkg::status_t status,
  output logic             res_write,
  output kfq_pkg::rsp_t    res
);
  import kfq_pkg::*;

  localparam int AddrBits  = $clog2(QUEUE_DEPTH);
  localparam int OccBits   = $clog2(QUEUE_DEPTH + 1);
  localparam int SumBits   = OccBits + 1;
  localparam int CmpBits   = (OccBits > RUN_W) ? OccBits : RUN_W;
  localparam int StoreBits = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  logic [AddrBits-1:0]        head;
  logic [OccBits-1:0]         occ;
  logic signed [FRAME_W:0]    last_key;
  logic [RUN_W-1:0]           run;

  logic                       is_key;
  logic                       flush;
  logic [CmpBits-1:0]         run_ext;
  logic [CmpBits-1:0]         occ_ext;
  logic [CmpBits-1:0]         drop_wide;
  logic [DROP_W-1:0]          drop;
  logic [OccBits-1:0]         occ_after;
  logic                       full;
  logic [SumBits-1:0]         tail_sum;
  logic [SumBits-1:0]         tail_wrap;
  logic [AddrBits-1:0]        tail;
  logic                       store_we;
  logic [AddrBits-1:0]        head_inc;
  logic [StoreBits-1:0]       rdata;

  // keyframe flush decision and tail rewind
  always_comb begin
    is_key    = (req.key_flag_byte == KEY_MARK);
    flush     = is_key && (req.segment_byte == SEG_START) &&
                ($signed({1'b0, req.frame_number}) > last_key);
    run_ext   = CmpBits'(run);
    occ_ext   = CmpBits'(occ);
    drop_wide = (run_ext < occ_ext) ? run_ext : occ_ext;
    drop      = flush ? drop_wide[DROP_W-1:0] : '0;
    occ_after = flush ? (occ - OccBits'(drop_wide)) : occ;
    full      = (occ_after == OccBits'(QUEUE_DEPTH));
    tail_sum  = SumBits'(head) + SumBits'(occ_after);
    tail_wrap = (tail_sum >= SumBits'(QUEUE_DEPTH)) ?
                (tail_sum - SumBits'(QUEUE_DEPTH)) : tail_sum;
    tail      = tail_wrap[AddrBits-1:0];
    store_we  = cmd.push && !full;
    head_inc  = (head == AddrBits'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  end

  // queue state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      occ      <= '0;
      last_key <= LAST_KEY_RESET;
      run      <= '0;
    end else if (cmd.push) begin
      if (flush) begin
        last_key <= $signed({1'b0, req.frame_number});
      end
      if (full) begin
        occ <= occ_after;
      end else begin
        occ <= occ_after + 1'b1;
        if (is_key) begin
          run <= '0;
        end else if (run != RUN_MAX) begin
          run <= run + 1'b1;
        end
      end
    end else if (cmd.pull_read) begin
      head <= head_inc;
      occ  <= occ - 1'b1;
    end
  end

  // handle store
  kfq_ram #(
    .WIDTH (StoreBits),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (tail),
    .wdata (req.packet_handle[StoreBits-1:0]),
    .re    (cmd.pull_read),
    .raddr (head),
    .rdata (rdata)
  );

  // result assembly
  always_comb begin
    res_write = cmd.push || cmd.pull_empty || cmd.pull_done;
    res       = '0;
    if (cmd.pull_done) begin
      res.out_handle = HANDLE_W'(rdata);
      res.out_valid  = 1'b1;
    end else if (cmd.push) begin
      res.dropped_count = drop;
      res.push_refused  = full;
    end
  end

  assign status.nonempty = (occ != '0);

endmodule

>>> hdl/kfq_obuf.sv
// Two-entry result buffer in front of the response channel.
// Depends on kfq_pkg.
module kfq_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  kfq_pkg::rsp_t wdata,
  output logic          space,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output kfq_pkg::rsp_t rsp
);
  import kfq_pkg::*;

  logic [1:0] count;
  rsp_t       slot0;
  rsp_t       slot1;
  logic       pop;
  logic [1:0] fill;

  assign pop  = (count != 2'd0) && !rsp_stall;
  assign fill = count - {1'b0, pop};

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, wr} - {1'b0, pop};
    end
  end

  // slots: slot0 is the head, slot1 moves up on a transfer
  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      slot0 <= slot1;
    end
    if (wr) begin
      if (fill == 2'd0) begin
        slot0 <= wdata;
      end else begin
        slot1 <= wdata;
      end
    end
  end

  assign space     = (count != 2'd2);
  assign rsp_valid = (count != 2'd0);
  assign rsp       = slot0;

endmodule

>>> hdl/keyframe_flushing_packet_queue_unit.sv
// Top level of the keyframe flushing packet queue.
// Depends on kfq_pkg, kfq_ctrl, kfq_dpath, kfq_obuf and the defines header.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------
//   req     | in        | req_valid / req_stall | kfq_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_stall | kfq_pkg::rsp_t
//
// On a push, flush, tail rewind and store write happen at the transfer. A pull
// waits in ST_READ for the registered read port of the handle store; a pull on
// an empty queue does not.
// Results go to a two-entry buffer, so a new request is taken while one
// result waits; req_stall rises when the buffer is full or a read is open.
// Synchronous reset clears pointers, count and run; store contents stay.
`include "keyframe_flushing_packet_queue_unit_defines.svh"
module keyframe_flushing_packet_queue_unit #(
  parameter int QUEUE_DEPTH = 256,
  parameter int HANDLE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  kfq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output kfq_pkg::rsp_t rsp
);
  import kfq_pkg::*;

  cmd_t    cmd;
  status_t status;
  state_t  state;
  logic    out_space;
  logic    res_write;
  rsp_t    res;

  // controller
  kfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .opcode    (req.opcode),
    .status    (status),
    .out_space (out_space),
    .cmd       (cmd),
    .state     (state)
  );

  // datapath with handle store
  kfq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .res_write (res_write),
    .res       (res)
  );

  // result buffer
  kfq_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .wr        (res_write),
    .wdata     (res),
    .space     (out_space),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // checks
  `KFQ_ASSERT_NEXT(a_read_completes, cmd.pull_read, cmd.pull_done && state == ST_READ)
  `KFQ_ASSERT_SAME(a_read_blocks_req, state == ST_READ, req_stall)
  `KFQ_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.push, cmd.pull_read, cmd.pull_empty, cmd.pull_done}))
  `KFQ_ASSERT_SAME(a_result_has_room, res_write && state == ST_IDLE, out_space)

endmodule

>>> verif/keyframe_flushing_packet_queue_unit_tb.sv
// Self-checking testbench for the keyframe flushing packet queue.
// Depends on kfq_pkg and keyframe_flushing_packet_queue_unit; predicts every response locally.
module keyframe_flushing_packet_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kfq_pkg::*;

  localparam int DEPTH         = 256;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 240;
  localparam int PHASE_ITEMS   = 60;
  localparam int MAX_WAIT      = 18;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // queue model state
  logic [HANDLE_W-1:0] q_store [DEPTH];
  logic [7:0]          q_head;
  logic [8:0]          q_count;
  int                  last_key;
  logic [RUN_W-1:0]    run_len;

  rsp_t pending_results [$];
  int   mismatches = 0;
  int   cycles     = 0;
  int   stall_left = 0;
  bit   req_idle   = 1'b1;
  bit   rsp_idle   = 1'b1;

  keyframe_flushing_packet_queue_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) flag_error($sformatf("%s expected %h got %h", field, want, got));
  endfunction

  // expected response of one request; advances the queue model
  function automatic rsp_t queue_result(req_t r);
    rsp_t       res;
    logic       is_key;
    logic [8:0] drop;
    logic [7:0] tail;
    res = '0;
    if (r.opcode == OP_PULL) begin
      // pull from an empty queue leaves everything as is
      if (q_count != 0) begin
        res.out_handle = q_store[q_head];
        res.out_valid  = 1'b1;
        q_head++;
        q_count--;
      end
    end else begin
      is_key = (r.key_flag_byte == KEY_MARK);
      // newer segment-start keyframe rewinds the tail over the non-key run
      if (is_key && r.segment_byte == SEG_START && int'(r.frame_number) > last_key) begin
        drop              = (run_len < q_count) ? run_len : q_count;
        last_key          = int'(r.frame_number);
        q_count           = q_count - drop;
        res.dropped_count = drop;
      end
      // refused push leaves the run count alone
      if (q_count >= DEPTH) begin
        res.push_refused = 1'b1;
      end else begin
        tail          = q_head + q_count[7:0];
        q_store[tail] = r.packet_handle;
        q_count++;
        if (is_key) run_len = '0;
        else if (run_len != RUN_MAX) run_len++;
      end
    end
    return res;
  endfunction

  function automatic req_t push_req(logic [15:0] handle, logic [7:0] key, logic [15:0] frame,
                                    logic [7:0] seg);
    req_t r;
    r.opcode        = OP_PUSH;
    r.packet_handle = handle;
    r.key_flag_byte = key;
    r.frame_number  = frame;
    r.segment_byte  = seg;
    return r;
  endfunction

  // header fields of a pull carry noise
  function automatic req_t pull_req();
    req_t r;
    r        = push_req(16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
    r.opcode = OP_PULL;
    return r;
  endfunction

  function automatic req_t random_nonkey();
    logic [7:0] key;
    logic [7:0] seg;
    key = 8'($urandom_range(0, 255));
    if (key == KEY_MARK) key = ~KEY_MARK;
    seg = ($urandom_range(0, 3) == 0) ? SEG_START : 8'($urandom);
    return push_req(16'($urandom), key, 16'($urandom), seg);
  endfunction

  // keyframe that starts a segment with a frame just past the recorded one
  function automatic req_t newer_keyframe();
    return push_req(16'($urandom), KEY_MARK, 16'(last_key + $urandom_range(1, 40)), SEG_START);
  endfunction

  // mostly group-of-pictures traffic, with stale and off-segment keyframes as noise
  function automatic req_t random_item(int pull_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < pull_pct) return pull_req();
    if (pick < 12 && last_key < 65000) return newer_keyframe();
    if (pick < 16)
      return push_req(16'($urandom), KEY_MARK,
                      16'((last_key < 0) ? 0 : $urandom_range(0, last_key)), SEG_START);
    if (pick < 20)
      return push_req(16'($urandom), KEY_MARK, 16'($urandom), 8'($urandom_range(1, 255)));
    return random_nonkey();
  endfunction

  // one request transfer, then record its expected response
  task automatic send_item(req_t item);
    int gap;
    gap = req_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pending_results = {pending_results, queue_result(item)};
  endtask

  // hold off requests until every response is back
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // response side back-pressure, drawn per transfer
  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall) stall_left = rsp_idle ? $urandom_range(0, MAX_WAIT) : 0;
    else if (stall_left > 0) stall_left--;
    rsp_stall <= (stall_left != 0);
  end

  // response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("response %h with nothing pending", rsp));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        check_field("out_handle", want.out_handle, rsp.out_handle);
        check_field("out_valid", want.out_valid, rsp.out_valid);
        check_field("dropped_count", want.dropped_count, rsp.dropped_count);
        check_field("push_refused", want.push_refused, rsp.push_refused);
      end
    end
  end

  // field extremes, both operations and the basic flush rules
  task automatic test_basic_ops();
    send_item(pull_req());
    send_item(push_req(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF));
    send_item(push_req(16'h0000, 8'h00, 16'h0000, SEG_START));
    send_item(push_req(16'h1234, 8'h02, 16'h0005, SEG_START));
    // first segment-start keyframe beats the reset frame and drops all three
    send_item(push_req(16'hA5A5, KEY_MARK, 16'h0000, SEG_START));
    send_item(random_nonkey());
    // same frame again: no flush, run still cleared
    send_item(push_req(16'h5A5A, KEY_MARK, 16'h0000, SEG_START));
    send_item(random_nonkey());
    send_item(random_nonkey());
    // keyframe inside a segment: no flush
    send_item(push_req(16'h0F0F, KEY_MARK, 16'h0064, 8'h01));
    send_item(random_nonkey());
    // newer frame flushes the single non-key since the last keyframe
    send_item(push_req(16'hF0F0, KEY_MARK, 16'h0064, SEG_START));
    // empty the queue and pull once more
    repeat (8) send_item(pull_req());
    wait_drained();
  endtask

  // full queue, refused pushes, run saturation and flushes that free room
  task automatic test_full_queue();
    req_idle = 1'b0;
    rsp_idle = 1'b1;
    repeat (DEPTH) send_item(random_nonkey());
    send_item(random_nonkey());
    send_item(push_req(16'($urandom), KEY_MARK, 16'($urandom), 8'hC3));
    repeat (DEPTH) send_item(pull_req());
    req_idle = 1'b1;
    rsp_idle = 1'b0;
    // second fill drives the run count up to its ceiling
    repeat (DEPTH) send_item(random_nonkey());
    send_item(newer_keyframe());
    repeat (DEPTH - 1) send_item(random_nonkey());
    // full queue, flush frees room for the keyframe
    send_item(newer_keyframe());
    repeat (DEPTH - 1) send_item(push_req(16'($urandom), KEY_MARK, 16'($urandom), 8'h80));
    // full queue, empty run: nothing flushed, push refused
    send_item(newer_keyframe());
    rsp_idle = 1'b1;
    repeat (DEPTH) send_item(pull_req());
    wait_drained();
  endtask

  // random traffic in phases of differing pull rate and idling
  task automatic test_random();
    int pull_pct;
    pull_pct = 45;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        case ($urandom_range(0, 2))
          0: pull_pct = 20;
          1: pull_pct = 45;
          default: pull_pct = 70;
        endcase
        req_idle = ($urandom_range(0, 2) != 0);
        rsp_idle = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 3) == 0) wait_drained();
      end
      send_item(random_item(pull_pct));
    end
    wait_drained();
  endtask

  // largest frame number, then equal and smaller ones that must not flush
  task automatic test_frame_ceiling();
    req_idle = 1'b1;
    rsp_idle = 1'b1;
    send_item(random_nonkey());
    send_item(random_nonkey());
    send_item(push_req(16'($urandom), KEY_MARK, 16'hFFFF, SEG_START));
    send_item(random_nonkey());
    send_item(push_req(16'($urandom), KEY_MARK, 16'hFFFF, SEG_START));
    send_item(random_nonkey());
    send_item(push_req(16'($urandom), KEY_MARK, 16'h0000, SEG_START));
    repeat (4) send_item(pull_req());
    wait_drained();
  endtask

  initial begin
    q_head   = '0;
    q_count  = '0;
    last_key = int'(LAST_KEY_RESET);
    run_len  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_full_queue();
    test_random();
    test_frame_ceiling();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
